FILE: rtl/gdfs_pkg.sv
`timescale 1ns / 1ps
// Shared constants, request codes and inter-module structs of the DFS order engine.
// No dependencies; every other file imports this package.
package gdfs_pkg;

  localparam int MAX_NODES = 64;
  localparam int MAX_EDGES = 1024;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int NID_W     = 7;
  localparam int LINK_W    = $clog2(MAX_EDGES + 1);
  localparam int EADDR_W   = $clog2(MAX_EDGES);
  localparam int SP_W      = $clog2(MAX_NODES + 1);
  localparam int WGT_W     = 16;

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_EDGES);
  localparam logic [LINK_W-1:0] FILL_LIMIT = LINK_W'(MAX_EDGES - 2);

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_WALK  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_e;

  typedef struct packed {
    logic               head_rd;
    logic               link;
    logic [NODE_W-1:0]  head_addr;
    logic [NODE_W-1:0]  link_tgt;
    logic               edge_rd;
    logic [EADDR_W-1:0] edge_addr;
    logic               clear;
    logic               set_ovf;
  } store_cmd_t;

  typedef struct packed {
    logic [LINK_W-1:0] head_link;
    logic [NODE_W-1:0] edge_tgt;
    logic [LINK_W-1:0] edge_nxt;
    logic [LINK_W-1:0] fill;
    logic              ovf;
  } store_sts_t;

  typedef struct packed {
    logic              wr;
    logic [NODE_W-1:0] wr_addr;
    logic [LINK_W-1:0] wr_data;
    logic              rd;
    logic [NODE_W-1:0] rd_addr;
  } stack_cmd_t;

endpackage

FILE: rtl/gdfs_store.sv
`timescale 1ns / 1ps
// Forward-star edge store: list head table with valid bits, edge target and next memories,
// fill count and sticky overflow flag. Depends on gdfs_pkg.
module gdfs_store import gdfs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  store_cmd_t cmd_i,
  output store_sts_t sts_o
);

  logic [LINK_W-1:0]    head_mem [MAX_NODES];
  logic [NODE_W-1:0]    tgt_mem  [MAX_EDGES];
  logic [LINK_W-1:0]    nxt_mem  [MAX_EDGES];
  logic [MAX_NODES-1:0] head_vld_q;
  logic                 head_vq_q;
  logic [LINK_W-1:0]    head_q;
  logic [NODE_W-1:0]    tgt_q;
  logic [LINK_W-1:0]    nxt_q;
  logic [LINK_W-1:0]    fill_q;
  logic                 ovf_q;
  logic [LINK_W-1:0]    head_link;

  assign head_link = head_vq_q ? head_q : NULL_LINK;

  always_ff @(posedge clk_i) begin
    if (cmd_i.head_rd) begin
      head_q <= head_mem[cmd_i.head_addr];
    end
    if (cmd_i.link) begin
      head_mem[cmd_i.head_addr]   <= fill_q;
      tgt_mem[fill_q[EADDR_W-1:0]] <= cmd_i.link_tgt;
      nxt_mem[fill_q[EADDR_W-1:0]] <= head_link;
    end
    if (cmd_i.edge_rd) begin
      tgt_q <= tgt_mem[cmd_i.edge_addr];
      nxt_q <= nxt_mem[cmd_i.edge_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= '0;
      head_vq_q  <= 1'b0;
      fill_q     <= '0;
      ovf_q      <= 1'b0;
    end else begin
      if (cmd_i.head_rd) begin
        head_vq_q <= head_vld_q[cmd_i.head_addr];
      end
      if (cmd_i.clear) begin
        head_vld_q <= '0;
        fill_q     <= '0;
        ovf_q      <= 1'b0;
      end else begin
        if (cmd_i.link) begin
          head_vld_q[cmd_i.head_addr] <= 1'b1;
          fill_q <= fill_q + LINK_W'(1);
        end
        if (cmd_i.set_ovf) begin
          ovf_q <= 1'b1;
        end
      end
    end
  end

  assign sts_o.head_link = head_link;
  assign sts_o.edge_tgt  = tgt_q;
  assign sts_o.edge_nxt  = nxt_q;
  assign sts_o.fill      = fill_q;
  assign sts_o.ovf       = ovf_q;

endmodule

FILE: rtl/gdfs_stack.sv
`timescale 1ns / 1ps
// Walk stack memory holding the saved edge links of the nodes below the stack top.
// Depends on gdfs_pkg.
module gdfs_stack import gdfs_pkg::*; (
  input  logic              clk_i,
  input  stack_cmd_t        cmd_i,
  output logic [LINK_W-1:0] rd_data_o
);

  logic [LINK_W-1:0] stack_mem [MAX_NODES];
  logic [LINK_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      stack_mem[cmd_i.wr_addr] <= cmd_i.wr_data;
    end
    if (cmd_i.rd) begin
      rd_q <= stack_mem[cmd_i.rd_addr];
    end
  end

  assign rd_data_o = rd_q;

endmodule

FILE: rtl/graph_dfs_order_engine.sv
`timescale 1ns / 1ps
// Top level of the depth-first order engine: request sequencer, result staging and ports.
// Depends on gdfs_pkg, gdfs_store and gdfs_stack.

// The engine takes one request transaction at a time and is not ready until it is done.
// An add steps through ST_ADD1 to ST_ADD3, since both directed edges go through the single
// head table port as a read followed by a link write. A clear resets the head valid bits, the
// fill count and the overflow flag and needs no sweep after reset. A traversal walks each edge
// entry by an edge memory read followed by the link test, visits each node with a head read
// and a stack push or pop, and scans the roots in turn, with stalls whenever the result side
// holds back tready. Results are staged one behind, so the final node can carry tlast.
module graph_dfs_order_engine import gdfs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // from_node [6:0], to_node [13:7], edge_weight [29:14], zero fill [31:30]
  input  logic [31:0] s_axis_tdata,
  // req_type [1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // visited_node [6:0], edges_overflowed [7]
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_ADD1  = 4'd1;
  localparam logic [3:0] ST_ADD2  = 4'd2;
  localparam logic [3:0] ST_ADD3  = 4'd3;
  localparam logic [3:0] ST_ROOT  = 4'd4;
  localparam logic [3:0] ST_HEAD  = 4'd5;
  localparam logic [3:0] ST_LINK  = 4'd6;
  localparam logic [3:0] ST_EDGE  = 4'd7;
  localparam logic [3:0] ST_POP   = 4'd8;
  localparam logic [3:0] ST_FLUSH = 4'd9;

  logic [3:0]           st_q, st_d;
  logic [NID_W-1:0]     node_count_q;
  logic [NODE_W-1:0]    src_q, src_d, dst_q, dst_d;
  logic [NID_W-1:0]     root_q, root_d;
  logic [SP_W-1:0]      sp_q, sp_d;
  logic [LINK_W-1:0]    top_q, top_d;
  logic [MAX_NODES-1:0] marks_q, marks_d;
  logic                 pend_v_q, pend_v_d;
  logic [NID_W-1:0]     pend_node_q, pend_node_d;
  logic                 out_v_q, out_v_d;
  logic [NID_W-1:0]     out_node_q, out_node_d;
  logic                 out_last_q, out_last_d;
  logic                 out_ovf_q, out_ovf_d;

  store_cmd_t        scmd;
  store_sts_t        ssts;
  stack_cmd_t        kcmd;
  logic [LINK_W-1:0] stack_rd;

  logic              in_acc;
  logic [NID_W-1:0]  a_node, b_node, roots;
  logic              ends_ok;
  logic              out_free, can_emit, emit;
  logic [NID_W-1:0]  emit_node;

  gdfs_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (scmd),
    .sts_o  (ssts)
  );

  gdfs_stack u_stack (
    .clk_i     (clk_i),
    .cmd_i     (kcmd),
    .rd_data_o (stack_rd)
  );

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (st_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign a_node        = s_axis_tdata[6:0];
  assign b_node        = s_axis_tdata[13:7];
  assign ends_ok       = (a_node != '0) && (a_node <= NID_W'(MAX_NODES)) &&
                         (b_node != '0) && (b_node <= NID_W'(MAX_NODES));
  assign roots         = (node_count_q > NID_W'(MAX_NODES)) ? NID_W'(MAX_NODES) : node_count_q;
  assign out_free      = !out_v_q || m_axis_tready;
  assign can_emit      = !pend_v_q || out_free;

  always_comb begin
    st_d        = st_q;
    src_d       = src_q;
    dst_d       = dst_q;
    root_d      = root_q;
    sp_d        = sp_q;
    top_d       = top_q;
    marks_d     = marks_q;
    emit        = 1'b0;
    emit_node   = '0;
    scmd        = '0;
    kcmd        = '0;
    pend_v_d    = pend_v_q;
    pend_node_d = pend_node_q;
    out_v_d     = out_v_q && !m_axis_tready;
    out_node_d  = out_node_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;

    unique case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (s_axis_tuser)
            REQ_ADD: begin
              if (ends_ok) begin
                if (ssts.fill > FILL_LIMIT) begin
                  scmd.set_ovf = 1'b1;
                end else begin
                  src_d          = NODE_W'(a_node - NID_W'(1));
                  dst_d          = NODE_W'(b_node - NID_W'(1));
                  scmd.head_rd   = 1'b1;
                  scmd.head_addr = src_d;
                  st_d           = ST_ADD1;
                end
              end
            end
            REQ_WALK: begin
              marks_d = '0;
              root_d  = '0;
              sp_d    = '0;
              st_d    = ST_ROOT;
            end
            REQ_CLEAR: begin
              scmd.clear = 1'b1;
              marks_d    = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ADD1: begin
        scmd.link      = 1'b1;
        scmd.head_addr = src_q;
        scmd.link_tgt  = dst_q;
        st_d           = ST_ADD2;
      end
      ST_ADD2: begin
        scmd.head_rd   = 1'b1;
        scmd.head_addr = dst_q;
        st_d           = ST_ADD3;
      end
      ST_ADD3: begin
        scmd.link      = 1'b1;
        scmd.head_addr = dst_q;
        scmd.link_tgt  = src_q;
        st_d           = ST_IDLE;
      end
      ST_ROOT: begin
        if (root_q >= roots) begin
          st_d = ST_FLUSH;
        end else if (marks_q[root_q[NODE_W-1:0]]) begin
          root_d = root_q + NID_W'(1);
        end else if (can_emit) begin
          emit                          = 1'b1;
          emit_node                     = root_q + NID_W'(1);
          marks_d[root_q[NODE_W-1:0]]   = 1'b1;
          scmd.head_rd                  = 1'b1;
          scmd.head_addr                = root_q[NODE_W-1:0];
          st_d                          = ST_HEAD;
        end
      end
      ST_HEAD: begin
        top_d = ssts.head_link;
        sp_d  = sp_q + SP_W'(1);
        st_d  = ST_LINK;
      end
      ST_LINK: begin
        if (top_q >= ssts.fill) begin
          sp_d = sp_q - SP_W'(1);
          if (sp_q > SP_W'(1)) begin
            kcmd.rd      = 1'b1;
            kcmd.rd_addr = NODE_W'(sp_q - SP_W'(2));
            st_d         = ST_POP;
          end else begin
            root_d = root_q + NID_W'(1);
            st_d   = ST_ROOT;
          end
        end else begin
          scmd.edge_rd   = 1'b1;
          scmd.edge_addr = top_q[EADDR_W-1:0];
          st_d           = ST_EDGE;
        end
      end
      ST_EDGE: begin
        if (marks_q[ssts.edge_tgt]) begin
          top_d = ssts.edge_nxt;
          st_d  = ST_LINK;
        end else if (can_emit) begin
          top_d                  = ssts.edge_nxt;
          emit                   = 1'b1;
          emit_node              = NID_W'(ssts.edge_tgt) + NID_W'(1);
          marks_d[ssts.edge_tgt] = 1'b1;
          if (sp_q < SP_W'(MAX_NODES)) begin
            kcmd.wr        = 1'b1;
            kcmd.wr_addr   = NODE_W'(sp_q - SP_W'(1));
            kcmd.wr_data   = ssts.edge_nxt;
            scmd.head_rd   = 1'b1;
            scmd.head_addr = ssts.edge_tgt;
            st_d           = ST_HEAD;
          end else begin
            st_d = ST_LINK;
          end
        end
      end
      ST_POP: begin
        top_d = stack_rd;
        st_d  = ST_LINK;
      end
      ST_FLUSH: begin
        if (!pend_v_q) begin
          st_d = ST_IDLE;
        end else if (out_free) begin
          out_v_d    = 1'b1;
          out_node_d = pend_node_q;
          out_last_d = 1'b1;
          out_ovf_d  = ssts.ovf;
          pend_v_d   = 1'b0;
          st_d       = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase

    if (emit) begin
      if (pend_v_q) begin
        out_v_d    = 1'b1;
        out_node_d = pend_node_q;
        out_last_d = 1'b0;
        out_ovf_d  = ssts.ovf;
      end
      pend_v_d    = 1'b1;
      pend_node_d = emit_node;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= ST_IDLE;
      node_count_q <= NID_W'(MAX_NODES);
      root_q       <= '0;
      sp_q         <= '0;
      marks_q      <= '0;
      pend_v_q     <= 1'b0;
      out_v_q      <= 1'b0;
    end else begin
      st_q     <= st_d;
      root_q   <= root_d;
      sp_q     <= sp_d;
      marks_q  <= marks_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
      if (cfg_valid_i && cfg_ready_o) begin
        node_count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    src_q       <= src_d;
    dst_q       <= dst_d;
    top_q       <= top_d;
    pend_node_q <= pend_node_d;
    out_node_q  <= out_node_d;
    out_last_q  <= out_last_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_ovf_q, out_node_q};
  assign m_axis_tlast  = out_last_q;

endmodule

FILE: bench/graph_dfs_order_engine_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the depth-first order engine: tracks the edge store and root count, predicts
// the visit order of every traversal, and compares each result transaction field by field.
// Depends on gdfs_pkg for the node and edge limits and the request codes.
module graph_dfs_order_engine_checker import gdfs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // from_node [6:0], to_node [13:7], edge_weight [29:14], zero fill [31:30]
  input  logic [31:0] s_axis_tdata,
  // req_type [1:0]
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // visited_node [6:0], edges_overflowed [7]
  input  logic [7:0]  m_axis_tdata,
  input  logic        m_axis_tlast,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [6:0] node;
    logic       last;
    logic       ovf;
  } visit_t;

  logic [LINK_W-1:0] node_head [MAX_NODES];
  logic [NODE_W-1:0] arc_dst [MAX_EDGES];
  logic [LINK_W-1:0] arc_next [MAX_EDGES];
  logic [LINK_W-1:0] arc_used;
  logic              ovf_seen;
  logic [6:0]        root_cfg;

  visit_t visits_due[$];
  visit_t held_visit;
  int     visit_total;

  function automatic void wipe_graph();
    for (int i = 0; i < MAX_NODES; i++) node_head[i] = NULL_LINK;
    arc_used = '0;
    ovf_seen = 1'b0;
  endfunction

  function automatic void attach_arc(input logic [NODE_W-1:0] src, input logic [NODE_W-1:0] dst);
    arc_dst[arc_used]  = dst;
    arc_next[arc_used] = node_head[src];
    node_head[src]     = arc_used;
    arc_used           = arc_used + 1'b1;
  endfunction

  function automatic void add_edge(input logic [6:0] a, input logic [6:0] b);
    if (a != 0 && a <= MAX_NODES && b != 0 && b <= MAX_NODES) begin
      if (MAX_EDGES - int'(arc_used) < 2) begin
        ovf_seen = 1'b1;
      end else begin
        attach_arc(NODE_W'(a - 7'd1), NODE_W'(b - 7'd1));
        attach_arc(NODE_W'(b - 7'd1), NODE_W'(a - 7'd1));
      end
    end
  endfunction

  // The newest visit is held back so that the final one of a traversal can be marked last.
  function automatic void log_visit(input logic [NODE_W-1:0] idx);
    if (visit_total > 0) visits_due.insert(visits_due.size(), held_visit);
    held_visit.node = 7'(idx) + 7'd1;
    held_visit.last = 1'b0;
    held_visit.ovf  = ovf_seen;
    visit_total++;
  endfunction

  function automatic void predict_walk();
    logic [MAX_NODES-1:0] seen;
    logic [LINK_W-1:0]    frame_link [MAX_NODES];
    logic [LINK_W-1:0]    arc;
    logic [NODE_W-1:0]    nb;
    int                   roots;
    int                   depth;
    roots = (root_cfg > MAX_NODES) ? MAX_NODES : int'(root_cfg);
    seen = '0;
    visit_total = 0;
    for (int r = 0; r < roots; r++) begin
      if (!seen[r]) begin
        seen[r] = 1'b1;
        log_visit(NODE_W'(r));
        frame_link[0] = node_head[r];
        depth = 1;
        while (depth > 0) begin
          arc = frame_link[depth-1];
          if (arc >= arc_used) begin
            depth--;
          end else begin
            frame_link[depth-1] = arc_next[arc];
            nb = arc_dst[arc];
            if (!seen[nb]) begin
              seen[nb] = 1'b1;
              log_visit(nb);
              if (depth < MAX_NODES) begin
                frame_link[depth] = node_head[nb];
                depth++;
              end
            end
          end
        end
      end
    end
    if (visit_total > 0) begin
      held_visit.last = 1'b1;
      visits_due.insert(visits_due.size(), held_visit);
    end
  endfunction

  function automatic void check_visit();
    visit_t want;
    if (visits_due.size() == 0) begin
      $error("visited_node: no visit expected, got %0d", m_axis_tdata[6:0]);
      fail_count_o++;
    end else begin
      want = visits_due.pop_front();
      if (m_axis_tdata[6:0] !== want.node) begin
        $error("visited_node: expected %0d, got %0d", want.node, m_axis_tdata[6:0]);
        fail_count_o++;
      end
      if (m_axis_tlast !== want.last) begin
        $error("last_visit: expected %0d, got %0d", want.last, m_axis_tlast);
        fail_count_o++;
      end
      if (m_axis_tdata[7] !== want.ovf) begin
        $error("edges_overflowed: expected %0d, got %0d", want.ovf, m_axis_tdata[7]);
        fail_count_o++;
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_cfg = 7'(MAX_NODES);
      wipe_graph();
      visits_due.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_visit();
      if (cfg_valid_i && cfg_ready_o) root_cfg = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) begin
        case (s_axis_tuser)
          REQ_ADD:   add_edge(s_axis_tdata[6:0], s_axis_tdata[13:7]);
          REQ_WALK:  predict_walk();
          REQ_CLEAR: wipe_graph();
          default:   ;
        endcase
      end
      pending_o = visits_due.size();
    end
  end

endmodule

FILE: bench/graph_dfs_order_engine_test.sv
`timescale 1ns / 1ps
// Top of the depth-first order engine bench: clock, reset, request and root count stimulus,
// result back-pressure, a watchdog and the verdict.
// Depends on gdfs_pkg, the engine RTL and graph_dfs_order_engine_checker.
module graph_dfs_order_engine_test;
  import gdfs_pkg::*;

  localparam logic [1:0] REQ_UNUSED      = 2'd3;
  localparam int         SETTLE_CYCLES   = 16;
  localparam int         HOLD_CYCLES     = 400;
  localparam int         WATCHDOG_LIMIT  = 20000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [6:0]  cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  int mismatches;
  int visits_pending;
  int hold_req = 0;
  bit calm = 1'b0;
  bit sender_quiet = 1'b0;
  int quiet_cycles = 0;

  always #2 clk_i = ~clk_i;

  graph_dfs_order_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  graph_dfs_order_engine_checker order_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (mismatches),
    .pending_o     (visits_pending)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("** graph_dfs_order_engine: FAILED **");
        $finish;
      end
    end
  end

  initial begin : result_sink
    int hold_done;
    int hold_left;
    int gap_left;
    bit sink_quiet;
    hold_done = 0;
    hold_left = 0;
    gap_left = 0;
    sink_quiet = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_done) begin
        hold_done = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if ($urandom_range(0, 99) == 0) sink_quiet = !sink_quiet;
      if (!calm && !sink_quiet && hold_left == 0 && gap_left == 0 &&
          $urandom_range(0, 9) == 0) begin
        gap_left = $urandom_range(1, 13);
      end
      m_axis_tready <= (hold_left == 0 && gap_left == 0);
      if (hold_left > 0) begin
        hold_left--;
      end else if (gap_left > 0) begin
        gap_left--;
      end
    end
  end

  function automatic logic [6:0] rand_node_id();
    return 7'($urandom_range(0, 127));
  endfunction

  task automatic pace();
    int n;
    if (!calm && !sender_quiet && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 13);
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    if ($urandom_range(0, 24) == 0) sender_quiet = !sender_quiet;
  endtask

  task automatic push_req(input logic [1:0] kind, input logic [6:0] a, input logic [6:0] b,
                          input logic [15:0] w);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {2'b00, w, b, a};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pace();
  endtask

  task automatic push_walk();
    push_req(REQ_WALK, rand_node_id(), rand_node_id(), 16'($urandom));
  endtask

  task automatic await_quiet();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (visits_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_roots(input logic [6:0] v);
    await_quiet();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [6:0] pick_roots();
    case ($urandom_range(0, 7))
      0:       return 7'd0;
      1:       return 7'(MAX_NODES);
      2:       return 7'd127;
      3:       return 7'($urandom_range(MAX_NODES + 1, 127));
      default: return 7'($urandom_range(1, 12));
    endcase
  endfunction

  task automatic push_noise();
    case ($urandom_range(0, 3))
      0:       push_req(REQ_ADD, 7'd0, rand_node_id(), 16'($urandom));
      1:       push_req(REQ_ADD, 7'($urandom_range(MAX_NODES + 1, 127)), rand_node_id(),
                        16'($urandom));
      2:       push_req(REQ_UNUSED, rand_node_id(), rand_node_id(), 16'($urandom));
      default: push_req(REQ_ADD, 7'($urandom_range(1, MAX_NODES)),
                        7'($urandom_range(MAX_NODES + 1, 127)), 16'($urandom));
    endcase
  endtask

  task automatic push_edges(input int count, input int span);
    repeat (count) begin
      if ($urandom_range(0, 7) == 0) begin
        push_noise();
      end else begin
        push_req(REQ_ADD, 7'($urandom_range(1, span)), 7'($urandom_range(1, span)),
                 16'($urandom));
      end
    end
  endtask

  // A graph is usually rebuilt from scratch, sometimes grown on top of the previous one.
  task automatic random_episode();
    int span;
    span = ($urandom_range(0, 5) == 0) ? MAX_NODES : $urandom_range(2, 12);
    if ($urandom_range(0, 3) != 0) begin
      push_req(REQ_CLEAR, rand_node_id(), rand_node_id(), 16'($urandom));
    end
    push_edges($urandom_range(0, 14), span);
    push_walk();
    if ($urandom_range(0, 1) == 1) begin
      push_edges($urandom_range(1, 5), span);
      push_walk();
    end
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_walk();
    write_roots(7'd0);
    push_req(REQ_WALK, 7'd127, 7'd127, 16'hFFFF);
    write_roots(7'd1);
    push_walk();
    write_roots(7'd127);
    push_walk();
    write_roots(7'd6);
    push_req(REQ_ADD, 7'd1, 7'd2, 16'h0000);
    push_req(REQ_ADD, 7'd1, 7'd3, 16'hFFFF);
    push_req(REQ_ADD, 7'd2, 7'd4, 16'h5A5A);
    push_req(REQ_ADD, 7'd3, 7'd3, 16'hA5A5);
    push_req(REQ_ADD, 7'd5, 7'(MAX_NODES), 16'h0001);
    push_req(REQ_ADD, 7'(MAX_NODES), 7'd1, 16'h8000);
    push_req(REQ_ADD, 7'd0, 7'd5, 16'h1234);
    push_req(REQ_ADD, 7'd5, 7'd0, 16'h4321);
    push_req(REQ_ADD, 7'(MAX_NODES + 1), 7'd2, 16'hFFFF);
    push_req(REQ_ADD, 7'd2, 7'd127, 16'h0000);
    push_req(REQ_ADD, 7'd127, 7'd127, 16'hFFFF);
    push_req(REQ_UNUSED, 7'd1, 7'd2, 16'h00FF);
    push_walk();
    push_req(REQ_CLEAR, 7'd127, 7'd127, 16'hFFFF);
    push_walk();
    push_req(REQ_ADD, 7'd6, 7'd1, 16'hFF00);
    push_walk();

    for (int ep = 0; ep < 16; ep++) begin
      if (ep % 3 == 0) write_roots(pick_roots());
      if (ep == 7) begin
        write_roots(7'(MAX_NODES));
        hold_req <= hold_req + 1;
        repeat (4) push_walk();
      end
      if (ep == 11) await_quiet();
      random_episode();
    end

    write_roots(pick_roots());
    calm <= 1'b1;
    repeat (3) random_episode();

    await_quiet();
    if (mismatches == 0) begin
      $display("** graph_dfs_order_engine: PASSED **");
    end else begin
      $display("** graph_dfs_order_engine: FAILED **");
    end
    $finish;
  end

endmodule
